>>> rtl/core/axhdlc_pkg.sv
// Package for the AX.25 HDLC frame transmitter.
// Holds sizes, opcodes, register indexes, shared types and the CRC step.
// No dependencies.
`timescale 1ns / 1ps

package axhdlc_pkg;

  localparam int FRAME_BYTES = 256;
  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int LEN_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = (LEN_W > 8) ? LEN_W : 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam len_t STORE_LIMIT = len_t'(FRAME_BYTES - 2);
  localparam len_t FCS_LIMIT = len_t'(FRAME_BYTES);

  localparam logic [1:0] OP_ADDR = 2'd0;
  localparam logic [1:0] OP_INFO = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CONTROL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_ID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_FLAGS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POST_FLAGS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STUFF_RUN = 3'd4;

  localparam logic [7:0] RST_CONTROL = 8'd3;
  localparam logic [7:0] RST_PROTOCOL_ID = 8'd240;
  localparam logic [7:0] RST_PRE_FLAGS = 8'd30;
  localparam logic [7:0] RST_POST_FLAGS = 8'd10;
  localparam logic [2:0] RST_STUFF_RUN = 3'd5;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] FCS_XOR = 16'hFFFF;
  localparam logic [7:0] SSID_MASK = 8'h1F;
  localparam logic [7:0] SSID_BITS = 8'h60;
  localparam logic [7:0] ADDR_END_BIT = 8'h01;
  localparam logic [2:0] SSID_POS = 3'd6;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_STORE_HDR,
    CMD_START,
    CMD_TICK
  } cmd_e;

  typedef struct packed {
    cmd_e kind;
    logic clear;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] control;
    logic [7:0] protocol_id;
    logic [7:0] pre_flags;
    logic [7:0] post_flags;
    logic [2:0] stuff_run;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_PRE,
    PH_FRAME,
    PH_POST
  } phase_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CTRL,
    BK_PID,
    BK_FCS_HI,
    BK_TICK
  } back_state_e;

  // One byte of the reflected CRC-CCITT (polynomial 0x8408).
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    begin
      d = b ^ crc[7:0];
      d = d ^ {d[3:0], 4'h0};
      crc_step = {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'h00, d, 3'b000};
    end
  endfunction

endpackage

>>> rtl/core/axhdlc_front.sv
// Front end of the AX.25 HDLC frame transmitter: takes items, turns address
// characters into header bytes and queues classified commands for the back end.
// Depends on axhdlc_pkg.
`timescale 1ns / 1ps

module axhdlc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_address_i,
  input  logic                first_byte_i,
  output logic                busy_o,
  output logic                cmd_valid_o,
  output axhdlc_pkg::cmd_t    cmd_o,
  input  logic                cmd_pop_i
);

  axhdlc_pkg::cmd_t fifo_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [2:0]       apos_q, apos_d;
  logic [2:0]       apos_eff;
  logic             push, pop;
  logic [7:0]       addr_byte;
  axhdlc_pkg::cmd_t cmd_new;

  assign busy_o      = cnt_q[1];
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = start_i && !busy_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    apos_eff  = first_byte_i ? 3'd0 : apos_q;
    addr_byte = {data_byte_i[6:0], 1'b0};
    if (apos_eff == axhdlc_pkg::SSID_POS) begin
      addr_byte = (addr_byte & axhdlc_pkg::SSID_MASK) | axhdlc_pkg::SSID_BITS;
    end
    apos_d        = apos_q;
    cmd_new.kind  = axhdlc_pkg::CMD_TICK;
    cmd_new.clear = 1'b0;
    cmd_new.data  = data_byte_i;
    case (opcode_i)
      axhdlc_pkg::OP_ADDR: begin
        cmd_new.clear = first_byte_i;
        if (last_address_i) begin
          cmd_new.kind = axhdlc_pkg::CMD_STORE_HDR;
          cmd_new.data = addr_byte | axhdlc_pkg::ADDR_END_BIT;
          apos_d       = 3'd0;
        end else begin
          cmd_new.kind = axhdlc_pkg::CMD_STORE;
          cmd_new.data = addr_byte;
          apos_d       = (apos_eff == axhdlc_pkg::SSID_POS) ? 3'd0 : apos_eff + 3'd1;
        end
      end
      axhdlc_pkg::OP_INFO: begin
        cmd_new.kind  = axhdlc_pkg::CMD_STORE;
        cmd_new.clear = first_byte_i;
        apos_d        = apos_eff;
      end
      axhdlc_pkg::OP_START: begin
        cmd_new.kind = axhdlc_pkg::CMD_START;
      end
      default: begin
        cmd_new.kind = axhdlc_pkg::CMD_TICK;
      end
    endcase
    if (!push) begin
      apos_d = apos_q;
    end
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      apos_q   <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      apos_q   <= apos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> rtl/core/axhdlc_back.sv
// Back end of the AX.25 HDLC frame transmitter: frame store, CRC, bit
// serializer with zero stuffing and NRZI, and the tone result register.
// Depends on axhdlc_pkg.
`timescale 1ns / 1ps

module axhdlc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  axhdlc_pkg::cfg_t    cfg_i,
  input  logic                cmd_valid_i,
  input  axhdlc_pkg::cmd_t    cmd_i,
  output logic                cmd_pop_o,
  output logic                result_strobe_o,
  output logic                tone_o,
  output logic                store_full_o
);

  logic [7:0] mem [axhdlc_pkg::FRAME_BYTES];
  logic [7:0] rdata_q;

  axhdlc_pkg::back_state_e state_q, state_d;
  axhdlc_pkg::len_t        len_q, len_d, len_eff;
  logic [15:0]             crc_q, crc_d, crc_eff, fcs;
  logic [7:0]              fcs_hi_q, fcs_hi_d;
  logic                    overflow_q, overflow_d;
  axhdlc_pkg::phase_e      phase_q, phase_d;
  axhdlc_pkg::idx_t        idx_q, idx_d;
  logic [7:0]              shift_q, shift_d;
  logic                    stf_q, stf_d;
  logic [3:0]              bitpos_q, bitpos_d;
  logic [2:0]              run_q, run_d;
  logic                    level_q, level_d;
  logic                    pending_q, pending_d;
  logic                    strobe_q, strobe_d;
  logic                    tone_q, tone_d;
  logic                    full_q, full_d;

  logic                    store_req;
  axhdlc_pkg::len_t        store_limit;
  logic [7:0]              store_data;
  logic                    mem_we;

  assign result_strobe_o = strobe_q;
  assign tone_o          = tone_q;
  assign store_full_o    = full_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      axhdlc_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            axhdlc_pkg::CMD_STORE_HDR: state_d = axhdlc_pkg::BK_CTRL;
            axhdlc_pkg::CMD_START:     state_d = axhdlc_pkg::BK_FCS_HI;
            axhdlc_pkg::CMD_TICK:      state_d = axhdlc_pkg::BK_TICK;
            default:                   state_d = axhdlc_pkg::BK_IDLE;
          endcase
        end
      end
      axhdlc_pkg::BK_CTRL: state_d = axhdlc_pkg::BK_PID;
      default:             state_d = axhdlc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o   = 1'b0;
    store_req   = 1'b0;
    store_limit = axhdlc_pkg::STORE_LIMIT;
    store_data  = cmd_i.data;
    len_eff     = len_q;
    crc_eff     = crc_q;
    fcs         = crc_q ^ axhdlc_pkg::FCS_XOR;
    fcs_hi_d    = fcs_hi_q;
    overflow_d  = overflow_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    shift_d     = shift_q;
    stf_d       = stf_q;
    bitpos_d    = bitpos_q;
    run_d       = run_q;
    level_d     = level_q;
    pending_d   = pending_q;
    strobe_d    = 1'b0;
    tone_d      = tone_q;
    full_d      = full_q;
    case (state_q)
      axhdlc_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.clear) begin
            len_eff = '0;
            crc_eff = axhdlc_pkg::CRC_INIT;
          end
          case (cmd_i.kind)
            axhdlc_pkg::CMD_STORE, axhdlc_pkg::CMD_STORE_HDR: begin
              store_req = 1'b1;
            end
            axhdlc_pkg::CMD_START: begin
              store_req   = 1'b1;
              store_limit = axhdlc_pkg::FCS_LIMIT;
              store_data  = fcs[7:0];
              fcs_hi_d    = fcs[15:8];
              phase_d     = axhdlc_pkg::PH_PRE;
              idx_d       = '0;
              shift_d     = 8'h00;
              stf_d       = 1'b0;
              bitpos_d    = 4'd8;
              run_d       = 3'd0;
              level_d     = 1'b1;
              pending_d   = 1'b1;
            end
            default: begin
              store_req = 1'b0;
            end
          endcase
        end
      end
      axhdlc_pkg::BK_CTRL: begin
        store_req  = 1'b1;
        store_data = cfg_i.control;
      end
      axhdlc_pkg::BK_PID: begin
        store_req  = 1'b1;
        store_data = cfg_i.protocol_id;
      end
      axhdlc_pkg::BK_FCS_HI: begin
        store_req   = 1'b1;
        store_limit = axhdlc_pkg::FCS_LIMIT;
        store_data  = fcs_hi_q;
      end
      axhdlc_pkg::BK_TICK: begin
        strobe_d = 1'b1;
        tone_d   = pending_q;
        full_d   = overflow_q;
        if (bitpos_q[3]) begin
          shift_d  = axhdlc_pkg::FLAG_BYTE;
          stf_d    = 1'b0;
          bitpos_d = 4'd0;
          case (phase_q)
            axhdlc_pkg::PH_FRAME: begin
              if (idx_q < axhdlc_pkg::idx_t'(len_q)) begin
                shift_d = rdata_q;
                stf_d   = 1'b1;
                idx_d   = idx_q + axhdlc_pkg::idx_t'(1);
                if (idx_d >= axhdlc_pkg::idx_t'(len_q)) begin
                  phase_d = axhdlc_pkg::PH_POST;
                  idx_d   = '0;
                end
              end else begin
                phase_d = axhdlc_pkg::PH_POST;
                idx_d   = '0;
              end
            end
            axhdlc_pkg::PH_POST: begin
              idx_d = idx_q + axhdlc_pkg::idx_t'(1);
              if (idx_d >= axhdlc_pkg::idx_t'(cfg_i.post_flags)) begin
                phase_d = axhdlc_pkg::PH_PRE;
                idx_d   = '0;
              end
            end
            default: begin
              idx_d = idx_q + axhdlc_pkg::idx_t'(1);
              if (idx_d >= axhdlc_pkg::idx_t'(cfg_i.pre_flags)) begin
                phase_d = axhdlc_pkg::PH_FRAME;
                idx_d   = '0;
              end
            end
          endcase
        end
        if (shift_d[0]) begin
          run_d = run_q + 3'd1;
          if ((cfg_i.stuff_run != 3'd0) && (run_d >= cfg_i.stuff_run) && stf_d) begin
            shift_d[0] = 1'b0;
            run_d      = 3'd0;
          end else begin
            shift_d  = {1'b0, shift_d[7:1]};
            bitpos_d = bitpos_d + 4'd1;
          end
        end else begin
          run_d    = 3'd0;
          shift_d  = {1'b0, shift_d[7:1]};
          bitpos_d = bitpos_d + 4'd1;
          level_d  = ~level_q;
        end
        pending_d = level_d;
      end
      default: begin
        store_req = 1'b0;
      end
    endcase

    mem_we = 1'b0;
    len_d  = len_eff;
    crc_d  = crc_eff;
    if (store_req) begin
      if (len_eff < store_limit) begin
        mem_we = 1'b1;
        len_d  = len_eff + axhdlc_pkg::len_t'(1);
        crc_d  = axhdlc_pkg::crc_step(crc_eff, store_data);
      end else begin
        overflow_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= axhdlc_pkg::BK_IDLE;
      len_q      <= '0;
      crc_q      <= axhdlc_pkg::CRC_INIT;
      overflow_q <= 1'b0;
      phase_q    <= axhdlc_pkg::PH_PRE;
      idx_q      <= '0;
      shift_q    <= 8'h00;
      stf_q      <= 1'b0;
      bitpos_q   <= 4'd8;
      run_q      <= 3'd0;
      level_q    <= 1'b1;
      pending_q  <= 1'b1;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      crc_q      <= crc_d;
      overflow_q <= overflow_d;
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      shift_q    <= shift_d;
      stf_q      <= stf_d;
      bitpos_q   <= bitpos_d;
      run_q      <= run_d;
      level_q    <= level_d;
      pending_q  <= pending_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fcs_hi_q <= fcs_hi_d;
    tone_q   <= tone_d;
    full_q   <= full_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[len_eff[axhdlc_pkg::ADDR_W-1:0]] <= store_data;
    end
    rdata_q <= mem[idx_q[axhdlc_pkg::ADDR_W-1:0]];
  end

endmodule

>>> rtl/core/ax25_hdlc_frame_transmitter.sv
// Top level of the AX.25 HDLC frame transmitter: configuration registers and
// the front and back ends joined by a two-entry command queue.
// Depends on axhdlc_pkg, axhdlc_front and axhdlc_back.
`timescale 1ns / 1ps

// An item is taken when start_i is high and busy_o is low; busy_o rises only
// when the two-entry command queue is full. The back end executes one command
// at a time, limited by the single write port and the registered read of the
// frame store: a byte load is stored as its command is taken, the address
// character that ends the header is stored and then followed by the control
// and PID bytes, a start stores the FCS low byte and then the high byte, and a
// symbol tick reads the store, then steps a bit. For each tick the tone and
// the overflow flag appear for one cycle with result_strobe_o, registered
// after the tick's command has passed the command queue, the idle state and
// the tick state; the receiver cannot stall them.
module ax25_hdlc_frame_transmitter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [1:0]                           opcode_i,
  input  logic [7:0]                           data_byte_i,
  input  logic                                 last_address_i,
  input  logic                                 first_byte_i,
  output logic                                 result_strobe_o,
  output logic                                 tone_o,
  output logic                                 store_full_o,
  input  logic                                 cfg_we_i,
  input  logic [axhdlc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [axhdlc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  axhdlc_pkg::cfg_t cfg_q, cfg_d;
  axhdlc_pkg::cmd_t cmd;
  logic             cmd_valid;
  logic             cmd_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        axhdlc_pkg::REG_CONTROL:     cfg_d.control     = cfg_data_i;
        axhdlc_pkg::REG_PROTOCOL_ID: cfg_d.protocol_id = cfg_data_i;
        axhdlc_pkg::REG_PRE_FLAGS:   cfg_d.pre_flags   = cfg_data_i;
        axhdlc_pkg::REG_POST_FLAGS:  cfg_d.post_flags  = cfg_data_i;
        axhdlc_pkg::REG_STUFF_RUN:   cfg_d.stuff_run   = cfg_data_i[2:0];
        default:                     cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control     <= axhdlc_pkg::RST_CONTROL;
      cfg_q.protocol_id <= axhdlc_pkg::RST_PROTOCOL_ID;
      cfg_q.pre_flags   <= axhdlc_pkg::RST_PRE_FLAGS;
      cfg_q.post_flags  <= axhdlc_pkg::RST_POST_FLAGS;
      cfg_q.stuff_run   <= axhdlc_pkg::RST_STUFF_RUN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  axhdlc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .opcode_i       (opcode_i),
    .data_byte_i    (data_byte_i),
    .last_address_i (last_address_i),
    .first_byte_i   (first_byte_i),
    .busy_o         (busy_o),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  axhdlc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .result_strobe_o (result_strobe_o),
    .tone_o          (tone_o),
    .store_full_o    (store_full_o)
  );

endmodule

>>> verif/ax25_hdlc_frame_transmitter_tb.sv
// Self-checking testbench for the AX.25 HDLC frame transmitter: directed and random
// frame loads, starts and symbol ticks, scored against a cycle-free behavioral model.
// Depends on axhdlc_pkg and ax25_hdlc_frame_transmitter.
`timescale 1ns / 1ps

module ax25_hdlc_frame_transmitter_tb;
  import axhdlc_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam logic [15:0] CRC_POLY_REFLECTED = 16'h8408;

  typedef struct packed {
    logic tone;
    logic store_full;
  } tone_result_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       last_addr;
    logic       first_byte;
    logic       checked_here;
    logic       tone;
    logic       store_full;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [1:0]            opcode_i = OP_TICK;
  logic [7:0]            data_byte_i = 8'h00;
  logic                  last_address_i = 1'b0;
  logic                  first_byte_i = 1'b0;
  logic                  result_strobe_o;
  logic                  tone_o;
  logic                  store_full_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_CONTROL;
  logic [CFG_DATA_W-1:0] cfg_data_i = 8'h00;

  ax25_hdlc_frame_transmitter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .data_byte_i     (data_byte_i),
    .last_address_i  (last_address_i),
    .first_byte_i    (first_byte_i),
    .result_strobe_o (result_strobe_o),
    .tone_o          (tone_o),
    .store_full_o    (store_full_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Behavioral copy of the transmitter state.
  logic [7:0] m_store [FRAME_BYTES];
  len_t       m_len;
  logic [2:0] m_addr_pos;
  logic [15:0] m_crc;
  phase_e     m_phase;
  idx_t       m_index;
  logic [7:0] m_shift;
  logic       m_stuffable;
  logic [3:0] m_bitpos;
  logic [2:0] m_ones;
  logic       m_level;
  logic       m_next_tone;
  logic       m_dropped;
  cfg_t       m_cfg;

  tone_result_t tone_due_q[$];
  int errors = 0;
  int items_sent = 0;
  int tones_checked = 0;
  int frames_sent = 0;
  int settings_used = 1;
  int idle_pct = 0;

  stim_row_t dir_rows [25] = '{
    '{OP_TICK,  8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0},
    '{OP_ADDR,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{OP_ADDR,  8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_ADDR,  8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_ADDR,  8'h7F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_ADDR,  8'h55, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_ADDR,  8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_ADDR,  8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_INFO,  8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_INFO,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_INFO,  8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_START, 8'hA5, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{OP_TICK,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_TICK,  8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_START, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_INFO,  8'h12, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{OP_TICK,  8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{OP_ADDR,  8'h41, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{OP_INFO,  8'hC3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_ADDR,  8'h42, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_START, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  function automatic logic [15:0] fcs_accumulate(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY_REFLECTED) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void clear_frame();
    m_len = '0;
    m_addr_pos = '0;
    m_crc = CRC_INIT;
  endfunction

  function automatic void restart_line();
    m_phase = PH_PRE;
    m_index = '0;
    m_shift = 8'h00;
    m_stuffable = 1'b0;
    m_bitpos = 4'd8;
    m_ones = '0;
    m_level = 1'b1;
    m_next_tone = 1'b1;
  endfunction

  function automatic void model_reset();
    m_cfg = '{RST_CONTROL, RST_PROTOCOL_ID, RST_PRE_FLAGS, RST_POST_FLAGS, RST_STUFF_RUN};
    clear_frame();
    m_dropped = 1'b0;
    restart_line();
  endfunction

  function automatic void put_byte(input logic [7:0] b, input len_t limit);
    if (m_len < limit && int'(m_len) < FRAME_BYTES) begin
      m_store[m_len[ADDR_W-1:0]] = b;
      m_len = m_len + len_t'(1);
      m_crc = fcs_accumulate(m_crc, b);
    end else begin
      m_dropped = 1'b1;
    end
  endfunction

  function automatic void load_next_byte();
    m_shift = FLAG_BYTE;
    m_stuffable = 1'b0;
    case (m_phase)
      PH_FRAME: begin
        if (m_index < m_len) begin
          m_shift = m_store[m_index[ADDR_W-1:0]];
          m_stuffable = 1'b1;
          m_index = m_index + idx_t'(1);
          if (m_index >= m_len) begin
            m_phase = PH_POST;
            m_index = '0;
          end
        end else begin
          m_phase = PH_POST;
          m_index = '0;
        end
      end
      PH_POST: begin
        m_index = m_index + idx_t'(1);
        if (m_index >= idx_t'(m_cfg.post_flags)) begin
          m_phase = PH_PRE;
          m_index = '0;
        end
      end
      default: begin
        m_index = m_index + idx_t'(1);
        if (m_index >= idx_t'(m_cfg.pre_flags)) begin
          m_phase = PH_FRAME;
          m_index = '0;
        end
      end
    endcase
  endfunction

  function automatic logic line_step();
    if (m_bitpos >= 4'd8) begin
      load_next_byte();
      m_bitpos = '0;
    end
    if (m_shift[0]) begin
      m_ones = m_ones + 3'd1;
      if (m_cfg.stuff_run != '0 && m_ones >= m_cfg.stuff_run && m_stuffable) begin
        m_shift[0] = 1'b0;
        m_ones = '0;
      end else begin
        m_shift = m_shift >> 1;
        m_bitpos = m_bitpos + 4'd1;
      end
    end else begin
      m_ones = '0;
      m_shift = m_shift >> 1;
      m_bitpos = m_bitpos + 4'd1;
      m_level = ~m_level;
    end
    return m_level;
  endfunction

  // Applies one accepted transfer to the model; returns 1 when it yields a tone.
  function automatic logic model_transfer(input logic [1:0] op, input logic [7:0] data,
                                          input logic last_addr, input logic first_byte,
                                          output tone_result_t res);
    logic [7:0] b;
    logic [15:0] fcs;
    logic yields;
    res = '0;
    yields = 1'b0;
    case (op)
      OP_ADDR: begin
        if (first_byte) clear_frame();
        if (m_addr_pos == SSID_POS) b = ((data << 1) & SSID_MASK) | SSID_BITS;
        else b = data << 1;
        m_addr_pos = (m_addr_pos == SSID_POS) ? 3'd0 : m_addr_pos + 3'd1;
        if (last_addr) begin
          put_byte(b | ADDR_END_BIT, STORE_LIMIT);
          put_byte(m_cfg.control, STORE_LIMIT);
          put_byte(m_cfg.protocol_id, STORE_LIMIT);
          m_addr_pos = '0;
        end else begin
          put_byte(b, STORE_LIMIT);
        end
      end
      OP_INFO: begin
        if (first_byte) clear_frame();
        put_byte(data, STORE_LIMIT);
      end
      OP_START: begin
        fcs = m_crc ^ FCS_XOR;
        put_byte(fcs[7:0], FCS_LIMIT);
        put_byte(fcs[15:8], FCS_LIMIT);
        restart_line();
      end
      default: begin
        res.tone = m_next_tone;
        res.store_full = m_dropped;
        m_next_tone = line_step();
        yields = 1'b1;
      end
    endcase
    return yields;
  endfunction

  task automatic drive_item(input logic [1:0] op, input logic [7:0] data, input logic last_addr,
                            input logic first_byte, input logic checked_here,
                            input tone_result_t typed_res);
    tone_result_t res;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    data_byte_i <= data;
    last_address_i <= last_addr;
    first_byte_i <= first_byte;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    items_sent++;
    if (model_transfer(op, data, last_addr, first_byte, res)) begin
      tone_due_q.push_back(checked_here ? typed_res : res);
    end
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (tone_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_CONTROL:     m_cfg.control = val;
      REG_PROTOCOL_ID: m_cfg.protocol_id = val;
      REG_PRE_FLAGS:   m_cfg.pre_flags = val;
      REG_POST_FLAGS:  m_cfg.post_flags = val;
      REG_STUFF_RUN:   m_cfg.stuff_run = val[2:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input cfg_t c);
    write_reg(REG_CONTROL, c.control);
    write_reg(REG_PROTOCOL_ID, c.protocol_id);
    write_reg(REG_PRE_FLAGS, c.pre_flags);
    write_reg(REG_POST_FLAGS, c.post_flags);
    write_reg(REG_STUFF_RUN, {5'b00000, c.stuff_run});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic send_frame();
    int n_addr;
    int n_info;
    int span;
    n_addr = $urandom_range(1, 9);
    for (int i = 0; i < n_addr; i++) begin
      drive_item(OP_ADDR, 8'($urandom), i == n_addr - 1, i == 0, 1'b0, '0);
    end
    n_info = $urandom_range(0, 6);
    for (int i = 0; i < n_info; i++) begin
      drive_item(OP_INFO, ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom), 1'($urandom),
                 1'b0, 1'b0, '0);
    end
    drive_item(OP_START, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
    span = (int'(m_cfg.pre_flags) + int'(m_len) + int'(m_cfg.post_flags)) * 10 + 16;
    if (span > 120) span = 120;
    repeat ($urandom_range(8, span)) begin
      drive_item(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
    end
    frames_sent++;
  endtask

  task automatic run_random(input int budget);
    int goal;
    goal = items_sent + budget;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 8)) begin
          drive_item(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
        end
      end else begin
        send_frame();
      end
    end
  endtask

  always @(posedge clk_i) begin
    tone_result_t want;
    if (rst_ni && result_strobe_o === 1'b1) begin
      if (tone_due_q.size() == 0) begin
        $error("unexpected result: tone %b store_full %b", tone_o, store_full_o);
        errors++;
      end else begin
        want = tone_due_q.pop_front();
        tones_checked++;
        if (tone_o !== want.tone) begin
          $error("tone: expected %b, got %b", want.tone, tone_o);
          errors++;
        end
        if (store_full_o !== want.store_full) begin
          $error("store_full: expected %b, got %b", want.store_full, store_full_o);
          errors++;
        end
      end
    end
  end

  initial begin
    cfg_t rnd_cfg;
    model_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) begin
      drive_item(dir_rows[k].op, dir_rows[k].data, dir_rows[k].last_addr, dir_rows[k].first_byte,
                 dir_rows[k].checked_here,
                 tone_result_t'({dir_rows[k].tone, dir_rows[k].store_full}));
    end
    run_random(50);
    settle();

    write_settings('{8'h00, 8'hFF, 8'd1, 8'd1, 3'd1});
    idle_pct = 65;
    run_random(50);
    settle();

    write_settings('{8'hFF, 8'h00, 8'd255, 8'd255, 3'd7});
    idle_pct = 0;
    run_random(40);
    settle();

    for (int p = 0; p < 2; p++) begin
      rnd_cfg.control = 8'($urandom);
      rnd_cfg.protocol_id = 8'($urandom);
      rnd_cfg.pre_flags = 8'($urandom_range(1, 3));
      rnd_cfg.post_flags = 8'($urandom_range(1, 3));
      rnd_cfg.stuff_run = 3'($urandom_range(1, 7));
      write_settings(rnd_cfg);
      idle_pct = (p == 0) ? 35 : 65;
      run_random(50);
      settle();
    end

    // Fill the store past capacity; the overflow flag then stays set.
    rnd_cfg.control = 8'($urandom);
    rnd_cfg.protocol_id = 8'($urandom);
    rnd_cfg.pre_flags = 8'd1;
    rnd_cfg.post_flags = 8'd2;
    rnd_cfg.stuff_run = 3'($urandom_range(1, 7));
    write_settings(rnd_cfg);
    idle_pct = 35;
    drive_item(OP_INFO, 8'($urandom), 1'b0, 1'b1, 1'b0, '0);
    while (!m_dropped) begin
      if ($urandom_range(99) < 60) drive_item(OP_ADDR, 8'($urandom), 1'b1, 1'b0, 1'b0, '0);
      else drive_item(OP_INFO, 8'($urandom), 1'($urandom), 1'b0, 1'b0, '0);
    end
    drive_item(OP_START, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
    drive_item(OP_START, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
    drive_item(OP_INFO, 8'($urandom), 1'($urandom), 1'b0, 1'b0, '0);
    repeat (40) drive_item(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
    settle();

    $display("Run summary: %0d transfers under %0d register settings, %0d frames sent,",
             items_sent, settings_used, frames_sent);
    $display("%0d tone results compared, store overflow exercised at the end.", tones_checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $error("timed out with %0d tone results outstanding", tone_due_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
